// File: rtl/priority_ordered_table_unit_assert.svh
`ifndef PRIORITY_ORDERED_TABLE_UNIT_ASSERT_SVH
`define PRIORITY_ORDERED_TABLE_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define POTU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define POTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/potu_pkg.sv
package potu_pkg;

	// Default sizes
	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_ID_BITS     = 16;
	localparam int DEF_PRIO_BITS   = 8;

	// Reposition needs at least this many entries
	localparam int MIN_REPOS = 2;

	typedef logic [2:0] req_t;
	typedef logic [2:0] status_t;
	typedef logic [1:0] kind_t;

	// Request codes
	localparam req_t REQ_INSERT = 3'd0;
	localparam req_t REQ_REMOVE = 3'd1;
	localparam req_t REQ_REPOS  = 3'd2;
	localparam req_t REQ_MOVE   = 3'd3;
	localparam req_t REQ_LIST   = 3'd4;

	// Status codes
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_DUP       = 3'd1;
	localparam status_t ST_NOTFOUND  = 3'd2;
	localparam status_t ST_TOOFEW    = 3'd3;
	localparam status_t ST_FULL      = 3'd4;
	localparam status_t ST_NOMATCH   = 3'd5;
	localparam status_t ST_COLLECTED = 3'd6;

	// Move kinds
	localparam kind_t MV_UP     = 2'd0;
	localparam kind_t MV_DOWN   = 2'd1;
	localparam kind_t MV_TOP    = 2'd2;
	localparam kind_t MV_BOTTOM = 2'd3;

endpackage

// File: rtl/priority_ordered_table_unit.sv
// Each table entry visited is addressed, read from memory and then compared, so a request
// walks the entries that it searches, places over and shifts, plus its sequencing states;
// a move repeats the search, walk and shift for every marked id.
// Throughput: one request at a time; busy drops in the cycle that carries the last result.
// A list request emits one result per table entry; the receiver cannot stall.
// Reset clears the entry count, the move marks and the control state at once.
module priority_ordered_table_unit #(
	parameter int TABLE_DEPTH = potu_pkg::DEF_TABLE_DEPTH,
	parameter int ID_BITS     = potu_pkg::DEF_ID_BITS,
	parameter int PRIO_BITS   = potu_pkg::DEF_PRIO_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  potu_pkg::req_t                           req_type,
	input  logic [ID_BITS-1:0]                       node_id,
	input  logic [PRIO_BITS-1:0]                     priority_req,
	input  potu_pkg::kind_t                          move_kind,
	input  logic                                     last_id,
	output logic                                     result_strobe,
	output potu_pkg::status_t                        status,
	output logic signed [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1):0] position,
	output logic [ID_BITS-1:0]                       entry_id,
	output logic                                     last_item
);
	import potu_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = PRIO_BITS + ID_BITS;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_WAIT    = 5'd1;
	localparam logic [4:0] S_FIND_RD = 5'd2;
	localparam logic [4:0] S_FIND_CK = 5'd3;
	localparam logic [4:0] S_PL_RD   = 5'd4;
	localparam logic [4:0] S_PL_CK   = 5'd5;
	localparam logic [4:0] S_DEL_RD  = 5'd6;
	localparam logic [4:0] S_DEL_CK  = 5'd7;
	localparam logic [4:0] S_INS_RD  = 5'd8;
	localparam logic [4:0] S_INS_CK  = 5'd9;
	localparam logic [4:0] S_ROTL_RD = 5'd10;
	localparam logic [4:0] S_ROTL_CK = 5'd11;
	localparam logic [4:0] S_ROTH_RD = 5'd12;
	localparam logic [4:0] S_ROTH_CK = 5'd13;
	localparam logic [4:0] S_EXT_RD  = 5'd14;
	localparam logic [4:0] S_EXT_CK  = 5'd15;
	localparam logic [4:0] S_IN_F    = 5'd16;
	localparam logic [4:0] S_RM_F    = 5'd17;
	localparam logic [4:0] S_RP_F    = 5'd18;
	localparam logic [4:0] S_RP_P    = 5'd19;
	localparam logic [4:0] S_RP_I    = 5'd20;
	localparam logic [4:0] S_MV_MARK = 5'd21;
	localparam logic [4:0] S_COL_RD  = 5'd22;
	localparam logic [4:0] S_COL_CK  = 5'd23;
	localparam logic [4:0] S_SEL_RD  = 5'd24;
	localparam logic [4:0] S_SEL_CK  = 5'd25;
	localparam logic [4:0] S_MV_EXT0 = 5'd26;
	localparam logic [4:0] S_ROT0    = 5'd27;
	localparam logic [4:0] S_MV_NEXT = 5'd28;
	localparam logic [4:0] S_LS_RD   = 5'd29;
	localparam logic [4:0] S_LS_CK   = 5'd30;
	localparam logic [4:0] S_EMIT    = 5'd31;

	logic [4:0]           state_q, rd_ret_q, sub_ret_q;
	logic [CW-1:0]        cnt_q, idx_q, pos_q, fidx_q, n_q;
	logic [AW-1:0]        k_q;
	logic [TABLE_DEPTH-1:0] marks_q;
	logic                 found_q, mk_q, lastid_q, emit_pos_q;
	logic [ID_BITS-1:0]   id_q;
	logic [PRIO_BITS-1:0] prio_q, fprio_q;
	kind_t                kind_q;
	status_t              res_st_q;

	// table RAM ports
	logic [WW-1:0]        mem_q [TABLE_DEPTH];
	logic [WW-1:0]        rdata_q, wdata_q;
	logic [AW-1:0]        raddr_q, waddr_q;
	logic                 wen_q;

	// selection RAM ports
	logic [ID_BITS-1:0]   sel_q [TABLE_DEPTH];
	logic [ID_BITS-1:0]   sel_rdata_q, sel_wdata_q;
	logic [AW-1:0]        sel_raddr_q, sel_waddr_q;
	logic                 sel_wen_q;

	// result registers
	logic                 strobe_q, last_item_q;
	status_t              status_q;
	logic signed [AW:0]   position_q;
	logic [ID_BITS-1:0]   entry_id_q;

	logic [ID_BITS-1:0]   rd_id;
	logic [PRIO_BITS-1:0] rd_prio;
	logic                 desc, to_lo;

	assign rd_id   = rdata_q[ID_BITS-1:0];
	assign rd_prio = rdata_q[WW-1:ID_BITS];
	assign desc    = (kind_q == MV_DOWN) || (kind_q == MV_TOP);
	assign to_lo   = (kind_q == MV_UP) || (kind_q == MV_TOP);

	// Table RAM with write-through on a same-address read
	always_ff @(posedge clk) begin
		if (wen_q)
			mem_q[waddr_q] <= wdata_q;
		if (wen_q && (waddr_q == raddr_q))
			rdata_q <= wdata_q;
		else
			rdata_q <= mem_q[raddr_q];
	end

	// Selection RAM holding marked ids in table order
	always_ff @(posedge clk) begin
		if (sel_wen_q)
			sel_q[sel_waddr_q] <= sel_wdata_q;
		sel_rdata_q <= sel_q[sel_raddr_q];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_ret_q    <= S_IDLE;
			sub_ret_q   <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			fidx_q      <= '0;
			n_q         <= '0;
			k_q         <= '0;
			marks_q     <= '0;
			found_q     <= 1'b0;
			mk_q        <= 1'b0;
			lastid_q    <= 1'b0;
			emit_pos_q  <= 1'b0;
			id_q        <= '0;
			prio_q      <= '0;
			fprio_q     <= '0;
			kind_q      <= MV_UP;
			res_st_q    <= ST_OK;
			raddr_q     <= '0;
			waddr_q     <= '0;
			wdata_q     <= '0;
			wen_q       <= 1'b0;
			sel_raddr_q <= '0;
			sel_waddr_q <= '0;
			sel_wdata_q <= '0;
			sel_wen_q   <= 1'b0;
			strobe_q    <= 1'b0;
			last_item_q <= 1'b0;
			status_q    <= ST_OK;
			position_q  <= '0;
			entry_id_q  <= '0;
		end else begin
			wen_q     <= 1'b0;
			sel_wen_q <= 1'b0;
			strobe_q  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						id_q       <= node_id;
						prio_q     <= priority_req;
						kind_q     <= move_kind;
						lastid_q   <= last_id;
						idx_q      <= '0;
						emit_pos_q <= 1'b0;
						case (req_type)
							REQ_INSERT: begin
								sub_ret_q <= S_IN_F;
								state_q   <= S_FIND_RD;
							end
							REQ_REMOVE: begin
								sub_ret_q <= S_RM_F;
								state_q   <= S_FIND_RD;
							end
							REQ_REPOS: begin
								if (cnt_q < CW'(MIN_REPOS)) begin
									res_st_q <= ST_TOOFEW;
									state_q  <= S_EMIT;
								end else begin
									sub_ret_q <= S_RP_F;
									state_q   <= S_FIND_RD;
								end
							end
							REQ_MOVE: begin
								sub_ret_q <= S_MV_MARK;
								state_q   <= S_FIND_RD;
							end
							REQ_LIST: begin
								if (cnt_q == '0) begin
									res_st_q <= ST_OK;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_LS_RD;
								end
							end
							default: ;
						endcase
					end
				end
				// wait state for the RAM read
				S_WAIT: state_q <= rd_ret_q;
				// search the table entries in order for id_q, stopping at the first match
				S_FIND_RD: begin
					if (idx_q == cnt_q) begin
						found_q <= 1'b0;
						state_q <= sub_ret_q;
					end else begin
						raddr_q  <= idx_q[AW-1:0];
						rd_ret_q <= S_FIND_CK;
						state_q  <= S_WAIT;
					end
				end
				S_FIND_CK: begin
					if (rd_id == id_q) begin
						found_q <= 1'b1;
						fidx_q  <= idx_q;
						fprio_q <= rd_prio;
						state_q <= sub_ret_q;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_FIND_RD;
					end
				end
				// find first entry with lower priority
				S_PL_RD: begin
					if (idx_q == cnt_q) begin
						pos_q   <= idx_q;
						state_q <= sub_ret_q;
					end else begin
						raddr_q  <= idx_q[AW-1:0];
						rd_ret_q <= S_PL_CK;
						state_q  <= S_WAIT;
					end
				end
				S_PL_CK: begin
					if (rd_prio < prio_q) begin
						pos_q   <= idx_q;
						state_q <= sub_ret_q;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_PL_RD;
					end
				end
				// close the gap at idx_q
				S_DEL_RD: begin
					if (idx_q + CW'(1) >= cnt_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= sub_ret_q;
					end else begin
						raddr_q  <= idx_q[AW-1:0] + AW'(1);
						rd_ret_q <= S_DEL_CK;
						state_q  <= S_WAIT;
					end
				end
				S_DEL_CK: begin
					wen_q   <= 1'b1;
					waddr_q <= idx_q[AW-1:0];
					wdata_q <= rdata_q;
					marks_q[idx_q[AW-1:0]] <= marks_q[idx_q[AW-1:0] + AW'(1)];
					idx_q   <= idx_q + CW'(1);
					state_q <= S_DEL_RD;
				end
				// open a gap at pos_q and place the new entry
				S_INS_RD: begin
					if (idx_q == pos_q) begin
						wen_q   <= 1'b1;
						waddr_q <= pos_q[AW-1:0];
						wdata_q <= {prio_q, id_q};
						marks_q[pos_q[AW-1:0]] <= mk_q;
						cnt_q   <= cnt_q + CW'(1);
						state_q <= sub_ret_q;
					end else begin
						raddr_q  <= idx_q[AW-1:0] - AW'(1);
						rd_ret_q <= S_INS_CK;
						state_q  <= S_WAIT;
					end
				end
				S_INS_CK: begin
					wen_q   <= 1'b1;
					waddr_q <= idx_q[AW-1:0];
					wdata_q <= rdata_q;
					marks_q[idx_q[AW-1:0]] <= marks_q[idx_q[AW-1:0] - AW'(1)];
					idx_q   <= idx_q - CW'(1);
					state_q <= S_INS_RD;
				end
				S_IN_F: begin
					if (found_q) begin
						res_st_q <= ST_DUP;
						state_q  <= S_EMIT;
					end else if (cnt_q == CW'(TABLE_DEPTH)) begin
						res_st_q <= ST_FULL;
						state_q  <= S_EMIT;
					end else begin
						mk_q    <= 1'b0;
						state_q <= S_RP_P;
					end
				end
				S_RM_F: begin
					if (!found_q) begin
						res_st_q <= ST_NOTFOUND;
						state_q  <= S_EMIT;
					end else begin
						res_st_q  <= ST_OK;
						idx_q     <= fidx_q;
						sub_ret_q <= S_EMIT;
						state_q   <= S_DEL_RD;
					end
				end
				S_RP_F: begin
					if (found_q) begin
						mk_q      <= marks_q[fidx_q[AW-1:0]];
						idx_q     <= fidx_q;
						sub_ret_q <= S_RP_P;
						state_q   <= S_DEL_RD;
					end else if (cnt_q == CW'(TABLE_DEPTH)) begin
						res_st_q <= ST_FULL;
						state_q  <= S_EMIT;
					end else begin
						mk_q    <= 1'b0;
						state_q <= S_RP_P;
					end
				end
				S_RP_P: begin
					idx_q     <= '0;
					sub_ret_q <= S_RP_I;
					state_q   <= S_PL_RD;
				end
				S_RP_I: begin
					idx_q      <= cnt_q;
					res_st_q   <= ST_OK;
					emit_pos_q <= 1'b1;
					sub_ret_q  <= S_EMIT;
					state_q    <= S_INS_RD;
				end
				// set the mark, then collect marked ids on the last one
				S_MV_MARK: begin
					if (found_q)
						marks_q[fidx_q[AW-1:0]] <= 1'b1;
					if (!lastid_q) begin
						res_st_q <= ST_COLLECTED;
						state_q  <= S_EMIT;
					end else begin
						idx_q   <= '0;
						n_q     <= '0;
						state_q <= S_COL_RD;
					end
				end
				S_COL_RD: begin
					if (idx_q == cnt_q) begin
						marks_q <= '0;
						if (n_q == '0) begin
							res_st_q <= ST_NOMATCH;
							state_q  <= S_EMIT;
						end else begin
							k_q     <= desc ? (n_q[AW-1:0] - AW'(1)) : '0;
							state_q <= S_SEL_RD;
						end
					end else begin
						raddr_q  <= idx_q[AW-1:0];
						rd_ret_q <= S_COL_CK;
						state_q  <= S_WAIT;
					end
				end
				S_COL_CK: begin
					if (marks_q[idx_q[AW-1:0]]) begin
						sel_wen_q   <= 1'b1;
						sel_waddr_q <= n_q[AW-1:0];
						sel_wdata_q <= rd_id;
						n_q         <= n_q + CW'(1);
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_COL_RD;
				end
				// fetch the next selected id and locate it
				S_SEL_RD: begin
					sel_raddr_q <= k_q;
					rd_ret_q    <= S_SEL_CK;
					state_q     <= S_WAIT;
				end
				S_SEL_CK: begin
					id_q      <= sel_rdata_q;
					idx_q     <= '0;
					sub_ret_q <= S_MV_EXT0;
					state_q   <= S_FIND_RD;
				end
				S_MV_EXT0: begin
					if (!found_q) begin
						state_q <= S_MV_NEXT;
					end else begin
						pos_q   <= fidx_q;
						state_q <= S_EXT_RD;
					end
				end
				// walk the target within the equal-priority run
				S_EXT_RD: begin
					if (to_lo) begin
						if (pos_q == '0 || (kind_q == MV_UP && pos_q != fidx_q)) begin
							state_q <= S_ROT0;
						end else begin
							raddr_q  <= pos_q[AW-1:0] - AW'(1);
							rd_ret_q <= S_EXT_CK;
							state_q  <= S_WAIT;
						end
					end else begin
						if (pos_q + CW'(1) >= cnt_q ||
						    (kind_q == MV_DOWN && pos_q != fidx_q)) begin
							state_q <= S_ROT0;
						end else begin
							raddr_q  <= pos_q[AW-1:0] + AW'(1);
							rd_ret_q <= S_EXT_CK;
							state_q  <= S_WAIT;
						end
					end
				end
				S_EXT_CK: begin
					if (rd_prio == fprio_q) begin
						pos_q   <= to_lo ? (pos_q - CW'(1)) : (pos_q + CW'(1));
						state_q <= S_EXT_RD;
					end else begin
						state_q <= S_ROT0;
					end
				end
				S_ROT0: begin
					idx_q <= fidx_q;
					if (pos_q < fidx_q)
						state_q <= S_ROTL_RD;
					else if (pos_q > fidx_q)
						state_q <= S_ROTH_RD;
					else
						state_q <= S_MV_NEXT;
				end
				// rotate entry toward the lower index
				S_ROTL_RD: begin
					if (idx_q == pos_q) begin
						wen_q   <= 1'b1;
						waddr_q <= pos_q[AW-1:0];
						wdata_q <= {fprio_q, id_q};
						state_q <= S_MV_NEXT;
					end else begin
						raddr_q  <= idx_q[AW-1:0] - AW'(1);
						rd_ret_q <= S_ROTL_CK;
						state_q  <= S_WAIT;
					end
				end
				S_ROTL_CK: begin
					wen_q   <= 1'b1;
					waddr_q <= idx_q[AW-1:0];
					wdata_q <= rdata_q;
					idx_q   <= idx_q - CW'(1);
					state_q <= S_ROTL_RD;
				end
				// rotate entry toward the higher index
				S_ROTH_RD: begin
					if (idx_q == pos_q) begin
						wen_q   <= 1'b1;
						waddr_q <= pos_q[AW-1:0];
						wdata_q <= {fprio_q, id_q};
						state_q <= S_MV_NEXT;
					end else begin
						raddr_q  <= idx_q[AW-1:0] + AW'(1);
						rd_ret_q <= S_ROTH_CK;
						state_q  <= S_WAIT;
					end
				end
				S_ROTH_CK: begin
					wen_q   <= 1'b1;
					waddr_q <= idx_q[AW-1:0];
					wdata_q <= rdata_q;
					idx_q   <= idx_q + CW'(1);
					state_q <= S_ROTH_RD;
				end
				// advance through the selection
				S_MV_NEXT: begin
					res_st_q <= ST_OK;
					if (desc) begin
						if (k_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							k_q     <= k_q - AW'(1);
							state_q <= S_SEL_RD;
						end
					end else begin
						if (CW'(k_q) + CW'(1) == n_q) begin
							state_q <= S_EMIT;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_SEL_RD;
						end
					end
				end
				// emit ids in table order
				S_LS_RD: begin
					raddr_q  <= idx_q[AW-1:0];
					rd_ret_q <= S_LS_CK;
					state_q  <= S_WAIT;
				end
				S_LS_CK: begin
					strobe_q    <= 1'b1;
					status_q    <= ST_OK;
					position_q  <= {1'b0, idx_q[AW-1:0]};
					entry_id_q  <= rd_id;
					last_item_q <= (idx_q + CW'(1) == cnt_q);
					if (idx_q + CW'(1) == cnt_q) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_LS_RD;
					end
				end
				S_EMIT: begin
					strobe_q    <= 1'b1;
					status_q    <= res_st_q;
					position_q  <= emit_pos_q ? {1'b0, pos_q[AW-1:0]} : '1;
					entry_id_q  <= '0;
					last_item_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign position      = position_q;
	assign entry_id      = entry_id_q;
	assign last_item     = last_item_q;

`include "priority_ordered_table_unit_assert.svh"

	`POTU_ASSERT_SAME(a_cnt_range, 1'b1, cnt_q <= CW'(TABLE_DEPTH), "entry count over depth")
	`POTU_ASSERT_SAME(a_final_idle, result_strobe && last_item, !busy, "final result while busy")
	`POTU_ASSERT_SAME(a_mid_busy, result_strobe && !last_item, busy, "list stopped early")
	`POTU_ASSERT_NEXT(a_cnt_step, 1'b1, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == $past(cnt_q) - CW'(1)), "count jumped")

endmodule

// File: tb/testbench.sv
module testbench;
	import potu_pkg::*;

	localparam int DEPTH  = DEF_TABLE_DEPTH;
	localparam int POS_W  = $clog2(DEPTH) + 1;
	localparam int SETTLE = 3 * 2 * DEPTH + 8;

	typedef struct {
		req_t             rq;
		logic [15:0]      nid;
		logic [7:0]       pr;
		kind_t            mk;
		logic             lid;
		int               idle_pct;
		bit               hold;
	} table_req_t;

	typedef struct {
		status_t                 st;
		logic signed [POS_W-1:0] pos;
		logic [15:0]             eid;
		logic                    li;
	} table_res_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	req_t                    req_type;
	logic [15:0]             node_id;
	logic [7:0]              priority_req;
	kind_t                   move_kind;
	logic                    last_id;
	logic                    result_strobe;
	status_t                 status;
	logic signed [POS_W-1:0] position;
	logic [15:0]             entry_id;
	logic                    last_item;

	priority_ordered_table_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.node_id       (node_id),
		.priority_req  (priority_req),
		.move_kind     (move_kind),
		.last_id       (last_id),
		.result_strobe (result_strobe),
		.status        (status),
		.position      (position),
		.entry_id      (entry_id),
		.last_item     (last_item)
	);

	table_req_t pending_reqs[$];
	table_res_t expected_results[$];
	table_req_t cur_req;
	bit         took;
	int         errors;

	// Shadow copy of the table
	logic [15:0] tbl_ids[DEPTH];
	logic [7:0]  tbl_prios[DEPTH];
	bit          tbl_marks[DEPTH];
	int          tbl_count;

	function automatic int find_entry(logic [15:0] id);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_ids[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void drop_entry(int p);
		for (int i = p; i + 1 < tbl_count; i++) begin
			tbl_ids[i]   = tbl_ids[i+1];
			tbl_prios[i] = tbl_prios[i+1];
			tbl_marks[i] = tbl_marks[i+1];
		end
		tbl_count--;
	endfunction

	function automatic void put_entry(int p, logic [15:0] id, logic [7:0] pr, bit mk);
		for (int i = tbl_count; i > p; i--) begin
			tbl_ids[i]   = tbl_ids[i-1];
			tbl_prios[i] = tbl_prios[i-1];
			tbl_marks[i] = tbl_marks[i-1];
		end
		tbl_ids[p]   = id;
		tbl_prios[p] = pr;
		tbl_marks[p] = mk;
		tbl_count++;
	endfunction

	function automatic int slot_for(logic [7:0] pr);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_prios[i] < pr)
				return i;
		return tbl_count;
	endfunction

	function automatic void shift_entry(int from, int to);
		logic [15:0] id;
		logic [7:0]  pr;
		bit          mk;
		if (from == to)
			return;
		id = tbl_ids[from];
		pr = tbl_prios[from];
		mk = tbl_marks[from];
		drop_entry(from);
		put_entry(to, id, pr, mk);
	endfunction

	// Move one entry within its run of equal priority
	function automatic void move_in_run(logic [15:0] id, kind_t kind);
		int p;
		int q;
		p = find_entry(id);
		if (p < 0)
			return;
		q = p;
		case (kind)
			MV_UP: begin
				if (p > 0 && tbl_prios[p-1] == tbl_prios[p])
					q = p - 1;
			end
			MV_DOWN: begin
				if (p + 1 < tbl_count && tbl_prios[p+1] == tbl_prios[p])
					q = p + 1;
			end
			MV_TOP: begin
				while (q > 0 && tbl_prios[q-1] == tbl_prios[p])
					q--;
			end
			default: begin
				while (q + 1 < tbl_count && tbl_prios[q+1] == tbl_prios[p])
					q++;
			end
		endcase
		shift_entry(p, q);
	endfunction

	function automatic void push_result(status_t st, int pos, logic [15:0] eid, logic li);
		table_res_t r;
		r.st  = st;
		r.pos = POS_W'(pos);
		r.eid = eid;
		r.li  = li;
		expected_results = {expected_results, r};
	endfunction

	// Apply one transaction to the shadow table and queue its results
	function automatic void predict_table(table_req_t t);
		int          f;
		int          p;
		int          n;
		bit          mk;
		logic [15:0] sel[DEPTH];
		case (t.rq)
			REQ_INSERT: begin
				if (find_entry(t.nid) >= 0)
					push_result(ST_DUP, -1, '0, 1'b1);
				else if (tbl_count >= DEPTH)
					push_result(ST_FULL, -1, '0, 1'b1);
				else begin
					p = slot_for(t.pr);
					put_entry(p, t.nid, t.pr, 1'b0);
					push_result(ST_OK, p, '0, 1'b1);
				end
			end
			REQ_REMOVE: begin
				f = find_entry(t.nid);
				if (f < 0)
					push_result(ST_NOTFOUND, -1, '0, 1'b1);
				else begin
					drop_entry(f);
					push_result(ST_OK, -1, '0, 1'b1);
				end
			end
			REQ_REPOS: begin
				mk = 1'b0;
				f = find_entry(t.nid);
				if (tbl_count < MIN_REPOS)
					push_result(ST_TOOFEW, -1, '0, 1'b1);
				else if (f < 0 && tbl_count >= DEPTH)
					push_result(ST_FULL, -1, '0, 1'b1);
				else begin
					if (f >= 0) begin
						mk = tbl_marks[f];
						drop_entry(f);
					end
					p = slot_for(t.pr);
					put_entry(p, t.nid, t.pr, mk);
					push_result(ST_OK, p, '0, 1'b1);
				end
			end
			REQ_MOVE: begin
				f = find_entry(t.nid);
				if (f >= 0)
					tbl_marks[f] = 1'b1;
				if (!t.lid)
					push_result(ST_COLLECTED, -1, '0, 1'b1);
				else begin
					n = 0;
					for (int i = 0; i < tbl_count; i++)
						if (tbl_marks[i]) begin
							sel[n] = tbl_ids[i];
							n++;
						end
					for (int i = 0; i < DEPTH; i++)
						tbl_marks[i] = 1'b0;
					if (n == 0)
						push_result(ST_NOMATCH, -1, '0, 1'b1);
					else begin
						if (t.mk == MV_DOWN || t.mk == MV_TOP) begin
							for (int i = n - 1; i >= 0; i--)
								move_in_run(sel[i], t.mk);
						end else begin
							for (int i = 0; i < n; i++)
								move_in_run(sel[i], t.mk);
						end
						push_result(ST_OK, -1, '0, 1'b1);
					end
				end
			end
			REQ_LIST: begin
				if (tbl_count == 0)
					push_result(ST_OK, -1, '0, 1'b1);
				for (int i = 0; i < tbl_count; i++)
					push_result(ST_OK, i, tbl_ids[i], i + 1 == tbl_count);
			end
			default: ;
		endcase
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: hold a transaction until accepted, then advance
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_reqs.size() > 0
				&& !(pending_reqs[0].hold && (expected_results.size() > 0 || busy))
				&& $urandom_range(99) >= pending_reqs[0].idle_pct) begin
				cur_req      = pending_reqs.pop_front();
				req_type     <= cur_req.rq;
				node_id      <= cur_req.nid;
				priority_req <= cur_req.pr;
				move_kind    <= cur_req.mk;
				last_id      <= cur_req.lid;
				start        <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predict on acceptance, check each strobed result
	always @(posedge clk) begin
		took = arst_n && start && !busy;
		if (took)
			predict_table(cur_req);
		if (arst_n && result_strobe) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d position %0d entry_id %0h",
					status, position, entry_id);
				errors++;
			end else begin
				table_res_t e;
				e = expected_results.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (position !== e.pos) begin
					$error("position: expected %0d actual %0d", e.pos, position);
					errors++;
				end
				if (entry_id !== e.eid) begin
					$error("entry_id: expected %0h actual %0h", e.eid, entry_id);
					errors++;
				end
				if (last_item !== e.li) begin
					$error("last_item: expected %0d actual %0d", e.li, last_item);
					errors++;
				end
			end
		end
	end

	logic [15:0] id_pool[24];
	int          pct;

	function automatic void add_req(req_t rq, logic [15:0] nid, logic [7:0] pr,
		kind_t mk, logic lid, bit hold);
		table_req_t t;
		t.rq       = rq;
		t.nid      = nid;
		t.pr       = pr;
		t.mk       = mk;
		t.lid      = lid;
		t.idle_pct = pct;
		t.hold     = hold;
		pending_reqs = {pending_reqs, t};
	endfunction

	function automatic logic [15:0] pick_id();
		if ($urandom_range(9) == 0)
			return 16'($urandom);
		return id_pool[$urandom_range(23)];
	endfunction

	function automatic logic [7:0] pick_prio();
		if ($urandom_range(4) == 0)
			return 8'($urandom);
		return 8'($urandom_range(3) * 8'h55);
	endfunction

	// Random phase: mostly well-formed requests and move selections
	function automatic void add_random(int cnt);
		int k;
		int sel_n;
		for (int i = 0; i < cnt; i++) begin
			k = $urandom_range(99);
			if (k < 30)
				add_req(REQ_INSERT, pick_id(), pick_prio(), kind_t'($urandom), 1'($urandom), 0);
			else if (k < 45)
				add_req(REQ_REMOVE, pick_id(), 8'($urandom), kind_t'($urandom), 1'($urandom), 0);
			else if (k < 60)
				add_req(REQ_REPOS, pick_id(), pick_prio(), kind_t'($urandom), 1'($urandom), 0);
			else if (k < 85) begin
				sel_n = $urandom_range(3);
				for (int j = 0; j < sel_n; j++)
					add_req(REQ_MOVE, pick_id(), 8'($urandom), kind_t'($urandom), 1'b0, 0);
				add_req(REQ_MOVE, pick_id(), 8'($urandom), kind_t'($urandom), 1'b1, 0);
			end else if (k < 93)
				add_req(REQ_LIST, 16'($urandom), 8'($urandom), kind_t'($urandom),
					1'($urandom), 0);
			else
				add_req(req_t'($urandom), 16'($urandom), 8'($urandom), kind_t'($urandom),
					1'($urandom), 0);
		end
	endfunction

	// Stimulus and end of run
	initial begin
		errors       = 0;
		took         = 0;
		tbl_count    = 0;
		for (int i = 0; i < DEPTH; i++)
			tbl_marks[i] = 1'b0;
		start        = 1'b0;
		req_type     = REQ_INSERT;
		node_id      = '0;
		priority_req = '0;
		move_kind    = MV_UP;
		last_id      = 1'b0;
		arst_n       = 1'b0;
		id_pool[0]   = 16'h0000;
		id_pool[1]   = 16'hFFFF;
		for (int i = 2; i < 24; i++)
			id_pool[i] = 16'($urandom);

		// Directed: empty table, too few, duplicates, absent ids, every move kind
		pct = 15;
		add_req(REQ_LIST,   16'h0000, 8'h00, MV_UP,     1'b0, 0);
		add_req(REQ_REPOS,  16'h0005, 8'h10, MV_UP,     1'b0, 0);
		add_req(REQ_INSERT, 16'h0000, 8'h00, MV_UP,     1'b0, 0);
		add_req(REQ_REPOS,  16'h0007, 8'h10, MV_UP,     1'b0, 0);
		add_req(REQ_INSERT, 16'hFFFF, 8'hFF, MV_BOTTOM, 1'b1, 0);
		add_req(REQ_INSERT, 16'h0000, 8'h40, MV_UP,     1'b0, 0);
		add_req(REQ_INSERT, 16'h0003, 8'hFF, MV_UP,     1'b0, 0);
		add_req(REQ_INSERT, 16'h0004, 8'hFF, MV_UP,     1'b0, 0);
		add_req(REQ_INSERT, 16'h0005, 8'h00, MV_UP,     1'b0, 0);
		add_req(REQ_REMOVE, 16'h0077, 8'h00, MV_UP,     1'b0, 0);
		add_req(REQ_REPOS,  16'h0003, 8'h80, MV_UP,     1'b0, 0);
		add_req(REQ_REPOS,  16'h0009, 8'h80, MV_UP,     1'b0, 0);
		add_req(REQ_MOVE,   16'h0077, 8'h00, MV_UP,     1'b0, 0);
		add_req(REQ_MOVE,   16'h0003, 8'h00, MV_UP,     1'b0, 0);
		add_req(REQ_MOVE,   16'h0009, 8'h00, MV_UP,     1'b1, 0);
		add_req(REQ_MOVE,   16'h0004, 8'h00, MV_DOWN,   1'b0, 0);
		add_req(REQ_MOVE,   16'hFFFF, 8'h00, MV_DOWN,   1'b1, 0);
		add_req(REQ_MOVE,   16'h0004, 8'h00, MV_TOP,    1'b1, 0);
		add_req(REQ_MOVE,   16'h0000, 8'h00, MV_BOTTOM, 1'b1, 0);
		add_req(REQ_MOVE,   16'h0123, 8'h00, MV_UP,     1'b1, 0);
		add_req(REQ_LIST,   16'h0000, 8'h00, MV_UP,     1'b0, 0);
		add_req(req_t'(5),  16'h1234, 8'h12, MV_UP,     1'b0, 0);
		add_req(req_t'(7),  16'hFFFF, 8'hFF, MV_BOTTOM, 1'b1, 0);
		add_req(REQ_REMOVE, 16'h0000, 8'h00, MV_UP,     1'b0, 0);
		add_req(REQ_LIST,   16'h0000, 8'h00, MV_UP,     1'b0, 0);
		add_random(8);

		// Receiver cannot stall, so the second phase differs only in sender gaps
		pct = 60;
		add_random(8);

		// Fill the table to full, then hit full insert and full reposition
		pct = 0;
		for (int i = 0; i < DEPTH + 2; i++)
			add_req(REQ_INSERT, 16'(16'h8000 + i * 37), pick_prio(), MV_UP, 1'b0, i == 0);
		add_req(REQ_REPOS, 16'h7FFF, 8'h33, MV_UP, 1'b0, 0);
		add_req(REQ_LIST, 16'h0000, 8'h00, MV_UP, 1'b0, 1);
		add_random(6);
		add_random(6);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || start)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (errors == 0 && expected_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Run limit
	initial begin
		#40000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/potu_pkg.sv
rtl/priority_ordered_table_unit.sv
tb/testbench.sv
